>>> rtl/core/skl_pkg.sv
package skl_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned SklCapacity = 1024;
  localparam int unsigned SklKeyBits  = 64;

  // Fixed port field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned KeyW    = 64;
  localparam int unsigned IdxW    = 10;
  localparam int unsigned CntOutW = 11;

  typedef enum logic [OpW-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CMP,
    ST_SHIFT,
    ST_INS,
    ST_RDWAIT,
    ST_FINISH
  } st_e;

endpackage

>>> rtl/core/skl_in_if.sv
interface skl_in_if;
  import skl_pkg::*;

  logic                valid;
  logic                ready;
  logic [OpW-1:0]      opcode;
  logic [KeyW-1:0]     key;
  logic [IdxW-1:0]     index;

  modport source (output valid, opcode, key, index, input ready);
  modport sink   (input valid, opcode, key, index, output ready);
endinterface

>>> rtl/core/skl_out_if.sv
interface skl_out_if;
  import skl_pkg::*;

  logic                valid;
  logic                ready;
  logic                found;
  logic                table_full;
  logic [CntOutW-1:0]  entry_count;
  logic [KeyW-1:0]     entry_key;

  modport source (output valid, found, table_full, entry_count, entry_key, input ready);
  modport sink   (input valid, found, table_full, entry_count, entry_key, output ready);
endinterface

>>> rtl/core/sorted_key_set_lookup_insert.sv
// Sorted key set: lookup, insert-if-absent, read by index. One item in flight at a time.
// Lookup and insert run a binary search of at most ceil(log2(count+1)) steps,
// one RAM read and one compare per step; an insert then moves each entry above its position
// up by one slot and writes the key. The next item is accepted in the cycle after the result
// is loaded; output stalls delay that load.
// Reset: entry count and handshake state clear asynchronously; key RAM is not cleared.
module sorted_key_set_lookup_insert import skl_pkg::*; #(
  parameter int unsigned CAPACITY = SklCapacity,
  parameter int unsigned KEY_BITS = SklKeyBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  skl_in_if.sink     in_i,
  skl_out_if.source  out_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  // FSM and search state
  st_e                 state_q, state_d;
  op_e                 op_q, op_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [CntW-1:0]     lo_q, lo_d;     // lower bound of search window / insert position
  logic [CntW-1:0]     hi_q, hi_d;
  logic [AddrW-1:0]    mid_q, mid_d;
  logic [AddrW-1:0]    src_q, src_d;   // shift source pointer, walks down
  logic                hit_q, hit_d;   // equality seen during search
  logic [CntW-1:0]     count_q, count_d;

  // pending result
  logic                res_found_q, res_found_d;
  logic                res_full_q, res_full_d;
  logic [KEY_BITS-1:0] res_key_q, res_key_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic                out_found_q, out_full_q;
  logic [CntOutW-1:0]  out_count_q;
  logic [KeyW-1:0]     out_key_q;
  logic                out_load;

  // RAM port
  logic                ram_we, ram_re;
  logic [AddrW-1:0]    ram_waddr, ram_raddr;
  logic [KEY_BITS-1:0] ram_wdata, ram_rdata;

  logic                in_xfer;
  logic                out_free;
  logic [CntW:0]       mid_sum;
  logic [CntW-1:0]     mid_full;
  logic                idx_ok;

  skl_ram #(
    .Width (KEY_BITS),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // midpoint of the current window; below hi whenever lo < hi, so it fits the address where used
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_full = mid_sum[CntW:1];

  // read-entry range check on the incoming index
  assign idx_ok = 32'(in_i.index) < 32'(count_q);

  // ---------------------------------------------------------------------------
  // Next state and datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    src_d       = src_q;
    hit_d       = hit_q;
    count_d     = count_q;
    res_found_d = res_found_q;
    res_full_d  = res_full_q;
    res_key_d   = res_key_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          op_d        = op_e'(in_i.opcode);
          key_d       = in_i.key[KEY_BITS-1:0];
          lo_d        = '0;
          hi_d        = count_q;
          hit_d       = 1'b0;
          res_found_d = 1'b0;
          res_full_d  = 1'b0;
          res_key_d   = '0;
          case (op_e'(in_i.opcode))
            OP_LOOKUP, OP_INSERT: state_d = ST_SEARCH;
            OP_READ: begin
              if (idx_ok) begin
                state_d = ST_RDWAIT;
              end else begin
                state_d = ST_FINISH;
              end
            end
            default: state_d = ST_FINISH;  // unused opcode: no effect
          endcase
        end
      end

      ST_SEARCH: begin
        if (lo_q < hi_q) begin
          mid_d   = AddrW'(mid_full);
          state_d = ST_CMP;
        end else if (op_q != OP_INSERT) begin
          res_found_d = hit_q;
          state_d     = ST_FINISH;
        end else if (hit_q) begin
          res_found_d = 1'b1;
          state_d     = ST_FINISH;
        end else if (count_q >= CntW'(CAPACITY)) begin
          res_full_d = 1'b1;
          state_d    = ST_FINISH;
        end else if (count_q == lo_q) begin
          state_d = ST_INS;            // append at the end, nothing to move
        end else begin
          src_d   = AddrW'(count_q - 1'b1);
          state_d = ST_SHIFT;
        end
      end

      ST_CMP: begin
        // ram_rdata holds key at mid_q
        if (ram_rdata < key_q) begin
          lo_d = CntW'(mid_q) + 1'b1;
        end else begin
          hi_d = CntW'(mid_q);
        end
        if (ram_rdata == key_q) begin
          hit_d = 1'b1;
        end
        state_d = ST_SEARCH;
      end

      ST_SHIFT: begin
        // move entry src up by one; stop once the insert position is vacated
        if (src_q == AddrW'(lo_q)) begin
          state_d = ST_INS;
        end else begin
          src_d = src_q - 1'b1;
        end
      end

      ST_INS: begin
        count_d = count_q + 1'b1;
        state_d = ST_FINISH;
      end

      ST_RDWAIT: begin
        res_found_d = 1'b1;
        res_key_d   = ram_rdata;
        state_d     = ST_FINISH;
      end

      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs: handshake and RAM control
  // ---------------------------------------------------------------------------
  always_comb begin
    in_i.ready = 1'b0;
    out_load   = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = ram_rdata;

    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        ram_re     = in_i.valid && (op_e'(in_i.opcode) == OP_READ) && idx_ok;
        ram_raddr  = AddrW'(in_i.index);
      end
      ST_SEARCH: begin
        if (lo_q < hi_q) begin
          ram_re    = 1'b1;
          ram_raddr = AddrW'(mid_full);
        end else if ((op_q == OP_INSERT) && !hit_q && (count_q < CntW'(CAPACITY))
                     && (count_q != lo_q)) begin
          ram_re    = 1'b1;
          ram_raddr = AddrW'(count_q - 1'b1);
        end
      end
      ST_SHIFT: begin
        // write the entry read last cycle one slot up, read the next one down
        ram_we    = 1'b1;
        ram_waddr = src_q + 1'b1;
        ram_wdata = ram_rdata;
        if (src_q != AddrW'(lo_q)) begin
          ram_re    = 1'b1;
          ram_raddr = src_q - 1'b1;
        end
      end
      ST_INS: begin
        ram_we    = 1'b1;
        ram_waddr = AddrW'(lo_q);
        ram_wdata = key_q;
      end
      ST_FINISH: begin
        out_load = out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    src_q       <= src_d;
    hit_q       <= hit_d;
    res_found_q <= res_found_d;
    res_full_q  <= res_full_d;
    res_key_q   <= res_key_d;
    if (out_load) begin
      out_found_q <= res_found_q;
      out_full_q  <= res_full_q;
      out_count_q <= CntOutW'(count_q);
      out_key_q   <= KeyW'(res_key_q);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found       = out_found_q;
  assign out_o.table_full  = out_full_q;
  assign out_o.entry_count = out_count_q;
  assign out_o.entry_key   = out_key_q;

endmodule

>>> rtl/core/skl_ram.sv
module skl_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
